### rtl/salwc_pkg.sv
// ============================================================================
// salwc_pkg
// Shared types and constants of the set-associative LRU write-back tag unit.
// ============================================================================
`default_nettype none

package salwc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 2'd2;

    localparam logic [3:0] OFFSET_RST = 4'd6;
    localparam logic [2:0] INDEX_RST  = 3'd6;
    localparam logic [2:0] WAYS_RST   = 3'd1;

    // Raw set index bits before the fold onto the physical sets
    localparam int RAW_SET_W = 7;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Access request
    typedef struct packed {
        logic [31:0] address;
        logic        write_op;
    } req_t;

    // Access result
    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        writeback;
        logic [1:0]  way_used;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
        logic [31:0] writeback_total;
    } rsp_t;

    // One way of one set in the tag RAM (valid bits live in flops)
    typedef struct packed {
        logic        dirty;
        logic [31:0] tag;
        logic [31:0] stamp;
    } line_t;

endpackage

`default_nettype wire

### rtl/salwc_queue.sv
// ============================================================================
// salwc_queue
// Small FIFO that decouples the classifying front end from the tag back end.
// ============================================================================
`default_nettype none

module salwc_queue
    import salwc_pkg::*;
#(
    parameter int WIDTH = 40
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_DEPTH);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/salwc_front.sv
// ============================================================================
// salwc_front
// Front end: holds the configuration and splits each address into set and tag.
// ============================================================================
`default_nettype none

module salwc_front
    import salwc_pkg::*;
#(
    parameter  int MAX_SETS = 64,
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire req_t                  request,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    input  wire logic                  full,
    output logic                       busy,
    output logic                       push,
    output logic      [SET_W+32:0]     entry,
    output logic      [2:0]            ways_cfg
);

    localparam logic [31:0] SETS_U = 32'(MAX_SETS);

    logic [3:0]           offset_reg;
    logic [2:0]           index_reg;
    logic [2:0]           ways_reg;
    logic [31:0]          shifted;
    logic [RAW_SET_W-1:0] raw_set;
    logic [RAW_SET_W-1:0] folded;
    logic [SET_W-1:0]     set_idx;
    logic [31:0]          tag;

    assign busy     = full;
    assign push     = start && !full;
    assign ways_cfg = ways_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            index_reg  <= INDEX_RST;
            ways_reg   <= WAYS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_OFFSET: offset_reg <= wr_data;
                REG_INDEX:  index_reg  <= wr_data[2:0];
                REG_WAYS:   ways_reg   <= wr_data[2:0];
                default:    ;
            endcase
        end
    end

    // Set index: mask to the index width, then fold onto the physical sets
    // by restoring subtraction of shifted copies of the set count.
    always_comb
    begin
        shifted = request.address >> offset_reg;
        raw_set = shifted[RAW_SET_W-1:0]
                & RAW_SET_W'((8'd1 << index_reg) - 8'd1);
        folded  = raw_set;
        for (int k = RAW_SET_W - 1; k >= 0; k--)
        begin
            if ({{(32-RAW_SET_W){1'b0}}, folded} >= (SETS_U << k))
            begin
                folded = folded - RAW_SET_W'(SETS_U << k);
            end
        end
        set_idx = SET_W'(folded);
    end

    // Tag excludes every index bit, including those folded away
    assign tag   = request.address >> (5'(offset_reg) + 5'(index_reg));
    assign entry = {request.write_op, tag, set_idx};

endmodule

`default_nettype wire

### rtl/salwc_back.sv
// ============================================================================
// salwc_back
// Back end: reads one set, resolves hit / fill / LRU eviction, writes it back.
// ============================================================================
`default_nettype none

module salwc_back
    import salwc_pkg::*;
#(
    parameter  int MAX_SETS = 64,
    parameter  int MAX_WAYS = 4,
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [2:0]       ways_cfg,
    input  wire logic             empty,
    input  wire logic [SET_W+32:0] pop_data,
    output logic                  pop,
    output logic                  done,
    output rsp_t                  result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;
    localparam logic [4:0] WAYS_MAX = 5'(MAX_WAYS);

    typedef line_t [MAX_WAYS-1:0] row_t;

    // Control state
    logic        state_reg, state_next;
    logic        done_reg;
    logic [31:0] access_reg, hit_cnt_reg, miss_cnt_reg, evict_cnt_reg, wb_cnt_reg;
    logic [MAX_WAYS-1:0] valid_reg [MAX_SETS];

    // Current access and its set
    logic [SET_W-1:0] cur_set_reg;
    logic [31:0]      cur_tag_reg;
    logic             cur_wr_reg;
    row_t             tag_ram [MAX_SETS];
    row_t             rd_row_reg;
    rsp_t             result_reg;

    // Evaluation
    logic                eval;
    logic [SET_W-1:0]    pop_set;
    logic [MAX_WAYS-1:0] valid_row;
    logic [4:0]          ways_lim;
    logic [MAX_WAYS-1:0] active, hit_vec, empty_vec, oldest_vec;
    logic                hit_any, empty_any, evicted, wb;
    logic [WAY_W-1:0]    way_sel;
    logic [31:0]         stamp_new;
    line_t               old_line;
    row_t                new_row;
    rsp_t                rsp;

    function automatic logic [WAY_W-1:0] first_way(input logic [MAX_WAYS-1:0] vec);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = WAY_W'(i);
            end
        end
        return idx;
    endfunction

    assign eval    = (state_reg == S_EVAL);
    assign pop     = !empty;
    assign pop_set = pop_data[SET_W-1:0];
    assign done    = done_reg;
    assign result  = result_reg;

    always_comb
    begin
        state_next = pop ? S_EVAL : S_IDLE;
    end

    // Ways in use: zero means one, above the physical count saturates
    always_comb
    begin
        if (ways_cfg == 3'd0)
        begin
            ways_lim = 5'd1;
        end
        else if (5'(ways_cfg) > WAYS_MAX)
        begin
            ways_lim = WAYS_MAX;
        end
        else
        begin
            ways_lim = 5'(ways_cfg);
        end
    end

    // Per-way match, empty and oldest-stamp flags
    always_comb
    begin
        logic beats;
        valid_row = valid_reg[cur_set_reg];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            active[i]    = (5'(i) < ways_lim);
            hit_vec[i]   = active[i] && valid_row[i]
                         && (rd_row_reg[i].tag == cur_tag_reg);
            empty_vec[i] = active[i] && !valid_row[i];
        end
        // A way is the victim if no earlier way is as old and no later one older
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            beats = active[i];
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (active[j] && j < i && !(rd_row_reg[i].stamp < rd_row_reg[j].stamp))
                begin
                    beats = 1'b0;
                end
                if (active[j] && j > i && !(rd_row_reg[i].stamp <= rd_row_reg[j].stamp))
                begin
                    beats = 1'b0;
                end
            end
            oldest_vec[i] = beats;
        end
    end

    // Way choice, row update and result
    always_comb
    begin
        hit_any   = |hit_vec;
        empty_any = |empty_vec;
        if (hit_any)
        begin
            way_sel = first_way(hit_vec);
        end
        else if (empty_any)
        begin
            way_sel = first_way(empty_vec);
        end
        else
        begin
            way_sel = first_way(oldest_vec);
        end
        old_line  = rd_row_reg[way_sel];
        evicted   = !hit_any && !empty_any;
        wb        = evicted && old_line.dirty;
        stamp_new = access_reg + 32'd1;

        new_row                = rd_row_reg;
        new_row[way_sel].dirty = hit_any ? (old_line.dirty | cur_wr_reg) : cur_wr_reg;
        new_row[way_sel].tag   = cur_tag_reg;
        new_row[way_sel].stamp = stamp_new;

        rsp.hit             = hit_any;
        rsp.evicted         = evicted;
        rsp.writeback       = wb;
        rsp.way_used        = 2'(way_sel);
        rsp.hit_total       = hit_cnt_reg + 32'(hit_any);
        rsp.miss_total      = miss_cnt_reg + 32'(!hit_any);
        rsp.eviction_total  = evict_cnt_reg + 32'(evicted);
        rsp.writeback_total = wb_cnt_reg + 32'(wb);
    end

    // Control registers, counters and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            access_reg    <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
            for (int s = 0; s < MAX_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= eval;
            if (eval)
            begin
                access_reg                    <= stamp_new;
                hit_cnt_reg                   <= rsp.hit_total;
                miss_cnt_reg                  <= rsp.miss_total;
                evict_cnt_reg                 <= rsp.eviction_total;
                wb_cnt_reg                    <= rsp.writeback_total;
                valid_reg[cur_set_reg][way_sel] <= 1'b1;
            end
        end
    end

    // Tag RAM: one row write and one registered row read per cycle,
    // with the row being written forwarded to a read of the same set.
    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            tag_ram[cur_set_reg] <= new_row;
        end
        if (eval && pop_set == cur_set_reg)
        begin
            rd_row_reg <= new_row;
        end
        else
        begin
            rd_row_reg <= tag_ram[pop_set];
        end
    end

    // Access payload and result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_set_reg <= pop_set;
            cur_tag_reg <= pop_data[SET_W+31:SET_W];
            cur_wr_reg  <= pop_data[SET_W+32];
        end
        if (eval)
        begin
            result_reg <= rsp;
        end
    end

endmodule

`default_nettype wire

### rtl/set_assoc_lru_writeback_cache_tags_unit.sv
// ============================================================================
// set_assoc_lru_writeback_cache_tags_unit
// Tag store of a set-associative write-back cache with LRU replacement.
// ============================================================================
// An access is taken on a clock edge with start high and busy low. Its result
// appears on result with done high for exactly one cycle, after the queue, the
// set read and the result register; the receiver must take it at the edge
// that ends that cycle. Accesses may be issued in every cycle: the tag RAM is
// read in one cycle and written in the next, and a row written while the next
// access reads the same set is forwarded, so the back end finishes one access
// per clock. busy rises only when the two-entry queue between front and back
// end is full; since the back end drains one entry every cycle, it stays low.
// Valid bits are flops cleared by reset, so no clearing pass is needed after
// reset. Configuration writes take effect at once and are meant for idle
// periods.
// ============================================================================
`default_nettype none

module set_assoc_lru_writeback_cache_tags_unit
    import salwc_pkg::*;
#(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire req_t                  request,
    output logic                       busy,
    output logic                       done,
    output rsp_t                       result,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENT_W = SET_W + 33;

    logic             push, pop, full, empty;
    logic [ENT_W-1:0] push_data, pop_data;
    logic [2:0]       ways_cfg;

    // Classify: configuration and address split
    salwc_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .full     (full),
        .busy     (busy),
        .push     (push),
        .entry    (push_data),
        .ways_cfg (ways_cfg)
    );

    // Decoupling queue
    salwc_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // Tag lookup, replacement and statistics
    salwc_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ways_cfg (ways_cfg),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

### rtl/salwc_checker.sv
// ============================================================================
// salwc_checker
// Port-level checks of the tag unit: result accounting and flag consistency.
// ============================================================================
`default_nettype none

module salwc_checker
    import salwc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    logic        accept;
    logic [2:0]  pending_reg, pending_next;
    logic [31:0] last_hit_reg, last_miss_reg, last_evict_reg;

    assign accept = start && !busy;

    // Accesses taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + 3'(accept) - 3'(done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_hit_reg   <= '0;
            last_miss_reg  <= '0;
            last_evict_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (done)
            begin
                last_hit_reg   <= result.hit_total;
                last_miss_reg  <= result.miss_total;
                last_evict_reg <= result.eviction_total;
            end
        end
    end

    // No result without an access in flight
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pending_reg != 3'd0)
        else $error("result transfer with no access in flight");

    // Queue, lookup stage and result register bound what can be in flight
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many accesses in flight");

    // Hit and miss totals advance by exactly this result
    a_hit_miss_totals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit_total == last_hit_reg + 32'(result.hit))
              && (result.miss_total == last_miss_reg + 32'(!result.hit)))
        else $error("hit/miss totals out of step");

    // Eviction total follows the evicted flag
    a_evict_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.eviction_total == last_evict_reg + 32'(result.evicted))
        else $error("eviction total out of step");

    // A hit never evicts; a writeback only comes with an eviction
    a_flag_consistency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.evicted)
              && !(result.writeback && !result.evicted))
        else $error("inconsistent hit/evict/writeback flags");

endmodule

bind set_assoc_lru_writeback_cache_tags_unit salwc_checker u_salwc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
